// File: rtl/bhpq_pkg.sv
`timescale 1ns / 1ps
package bhpq_pkg;
  localparam int CAPACITY_DEF = 64;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int TAG_WIDTH_DEF = 16;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_CHK,
    S_LAST_RD,
    S_LAST_WAIT,
    S_PAR_RD,
    S_PAR_CHK,
    S_CH_RD,
    S_CH_WAIT,
    S_CH_CHK,
    S_TOP_RD,
    S_TOP_WAIT,
    S_DONE
  } state_t;
endpackage

// File: rtl/bhpq_if.sv
`timescale 1ns / 1ps
interface bhpq_if #(
  parameter int W = 8
);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/bhpq_mem.sv
`timescale 1ns / 1ps
module bhpq_mem #(
  parameter int DEPTH = 64,
  parameter int W = 48,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/bhpq_ctrl.sv
`timescale 1ns / 1ps
module bhpq_ctrl
  import bhpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF,
  parameter int TAG_WIDTH = TAG_WIDTH_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int EW = KEY_WIDTH + TAG_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 max_first,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_op,
  input  logic [KEY_WIDTH-1:0] in_key,
  input  logic [TAG_WIDTH-1:0] in_tag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic                 out_top_valid,
  output logic [KEY_WIDTH-1:0] out_top_key,
  output logic [TAG_WIDTH-1:0] out_top_tag,
  output logic [CW-1:0]        out_count,
  output logic                 we,
  output logic [AW-1:0]        waddr,
  output logic [EW-1:0]        wdata,
  output logic [AW-1:0]        raddr,
  input  logic [EW-1:0]        rdata
);
  state_t state, state_next;
  logic [1:0] op;
  logic [TAG_WIDTH-1:0] tag;
  logic [CW-1:0] cnt;
  logic [CW:0] pos, idx;
  logic [EW-1:0] cur, lft;
  logic [1:0] status;
  logic cmp_chk;

  logic [CW-1:0] cnt_next;
  logic [CW:0] pos_next, idx_next;
  logic [EW-1:0] cur_next, lft_next;
  logic [1:0] status_next;
  logic out_valid_next;
  logic [KEY_WIDTH-1:0] top_key_next;
  logic [TAG_WIDTH-1:0] top_tag_next;
  logic top_valid_next;
  logic cmp_chk_next;

  logic [KEY_WIDTH-1:0] rk, ck, lk;
  logic [CW:0] par, lch;

  assign rk = rdata[EW-1:TAG_WIDTH];
  assign ck = cur[EW-1:TAG_WIDTH];
  assign lk = lft[EW-1:TAG_WIDTH];
  assign par = (pos - 1'b1) >> 1;
  assign lch = {pos[CW-1:0], 1'b1};

  function automatic logic goes_first(input logic mf, input logic [KEY_WIDTH-1:0] a,
                                      input logic [KEY_WIDTH-1:0] b);
    return mf ? (a > b) : (a < b);
  endfunction

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      out_valid <= out_valid_next;
    end
    pos <= pos_next;
    idx <= idx_next;
    cur <= cur_next;
    lft <= lft_next;
    status <= status_next;
    cmp_chk <= cmp_chk_next;
    out_top_key <= top_key_next;
    out_top_tag <= top_tag_next;
    out_top_valid <= top_valid_next;
    if (state == S_IDLE && in_valid && in_ready) begin
      op <= in_op;
      tag <= in_tag;
    end
  end

  assign out_status = status;
  assign out_count = cnt;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    pos_next = pos;
    idx_next = idx;
    cur_next = cur;
    lft_next = lft;
    status_next = status;
    cmp_chk_next = cmp_chk;
    out_valid_next = out_valid;
    top_key_next = out_top_key;
    top_tag_next = out_top_tag;
    top_valid_next = out_top_valid;
    we = 1'b0;
    waddr = pos[AW-1:0];
    wdata = cur;
    raddr = '0;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          status_next = ST_OK;
          state_next = S_TOP_RD;
          case (in_op)
            OP_PUSH: begin
              if (cnt == CW'(CAPACITY)) begin
                status_next = ST_FULL;
              end else begin
                cur_next = {in_key, in_tag};
                pos_next = {1'b0, cnt};
                cnt_next = cnt + 1'b1;
                cmp_chk_next = 1'b0;
                state_next = S_PAR_RD;
              end
            end
            OP_POP: begin
              if (cnt == '0) begin
                status_next = ST_EMPTY;
              end else begin
                cnt_next = cnt - 1'b1;
                pos_next = '0;
                state_next = S_LAST_RD;
              end
            end
            OP_REMOVE: begin
              if (cnt == '0) begin
                status_next = ST_NOT_FOUND;
              end else begin
                idx_next = '0;
                state_next = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        raddr = idx[AW-1:0];
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (rdata[TAG_WIDTH-1:0] == tag) begin
          cnt_next = cnt - 1'b1;
          pos_next = idx;
          if (idx == {1'b0, cnt - 1'b1}) begin
            state_next = S_TOP_RD;
          end else begin
            state_next = S_LAST_RD;
          end
        end else if (idx + 1'b1 == {1'b0, cnt}) begin
          status_next = ST_NOT_FOUND;
          state_next = S_TOP_RD;
        end else begin
          idx_next = idx + 1'b1;
          raddr = AW'(idx + 1'b1);
          state_next = S_SCAN_CHK;
        end
      end
      S_LAST_RD: begin
        raddr = cnt[AW-1:0];
        state_next = S_LAST_WAIT;
      end
      S_LAST_WAIT: begin
        cur_next = rdata;
        if (op == OP_REMOVE && pos != '0) begin
          cmp_chk_next = 1'b1;
          state_next = S_PAR_RD;
        end else begin
          cmp_chk_next = 1'b0;
          state_next = S_CH_RD;
        end
      end
      S_PAR_RD: begin
        if (pos == '0) begin
          we = 1'b1;
          state_next = S_TOP_RD;
        end else begin
          raddr = par[AW-1:0];
          state_next = S_PAR_CHK;
        end
      end
      S_PAR_CHK: begin
        if (goes_first(max_first, ck, rk)) begin
          we = 1'b1;
          wdata = rdata;
          cmp_chk_next = 1'b0;
          pos_next = par;
          state_next = S_PAR_RD;
        end else if (cmp_chk) begin
          cmp_chk_next = 1'b0;
          state_next = S_CH_RD;
        end else begin
          we = 1'b1;
          state_next = S_TOP_RD;
        end
      end
      S_CH_RD: begin
        if (lch >= {1'b0, cnt}) begin
          we = 1'b1;
          state_next = S_TOP_RD;
        end else begin
          raddr = lch[AW-1:0];
          state_next = S_CH_WAIT;
        end
      end
      S_CH_WAIT: begin
        lft_next = rdata;
        if (lch + 1'b1 < {1'b0, cnt}) begin
          raddr = AW'(lch + 1'b1);
          state_next = S_CH_CHK;
        end else begin
          if (goes_first(max_first, rk, ck)) begin
            we = 1'b1;
            wdata = rdata;
            pos_next = lch;
            state_next = S_CH_RD;
          end else begin
            we = 1'b1;
            state_next = S_TOP_RD;
          end
        end
      end
      S_CH_CHK: begin
        if (goes_first(max_first, rk, lk)) begin
          if (goes_first(max_first, rk, ck)) begin
            we = 1'b1;
            wdata = rdata;
            pos_next = lch + 1'b1;
            state_next = S_CH_RD;
          end else begin
            we = 1'b1;
            state_next = S_TOP_RD;
          end
        end else if (goes_first(max_first, lk, ck)) begin
          we = 1'b1;
          wdata = lft;
          pos_next = lch;
          state_next = S_CH_RD;
        end else begin
          we = 1'b1;
          state_next = S_TOP_RD;
        end
      end
      S_TOP_RD: begin
        raddr = '0;
        state_next = S_TOP_WAIT;
      end
      S_TOP_WAIT: begin
        top_valid_next = (cnt != '0);
        top_key_next = (cnt != '0) ? rk : '0;
        top_tag_next = (cnt != '0) ? rdata[TAG_WIDTH-1:0] : '0;
        out_valid_next = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_next) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

// File: rtl/binary_heap_priority_queue_top.sv
// A push rises level by level and a pop sinks level by level; a remove scans the entries
// in order and, when the hole is refilled from the last entry, sifts that entry into place;
// the result is given after the top entry is read back.
// One op at a time; the single memory read port, one read per compare, sets the rate.
// Synchronous reset empties the queue and sets max_first to 1; the entry
// memory is not cleared.
`timescale 1ns / 1ps
module binary_heap_priority_queue_top
  import bhpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF,
  parameter int TAG_WIDTH = TAG_WIDTH_DEF
) (
  input logic clk,
  input logic rst,
  bhpq_if.sink cfg,
  bhpq_if.sink in_ch,
  bhpq_if.source out_ch
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = KEY_WIDTH + TAG_WIDTH;

  logic max_first;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_first <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      max_first <= cfg.data[0];
    end
  end

  bhpq_mem #(.DEPTH(CAPACITY), .W(EW), .AW(AW)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  bhpq_ctrl #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH), .TAG_WIDTH(TAG_WIDTH)) u_ctrl (
    .clk, .rst, .max_first,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_op(in_ch.data[2+KEY_WIDTH+TAG_WIDTH-1 -: 2]),
    .in_key(in_ch.data[KEY_WIDTH+TAG_WIDTH-1 -: KEY_WIDTH]),
    .in_tag(in_ch.data[TAG_WIDTH-1:0]),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_status(out_ch.data[2+1+KEY_WIDTH+TAG_WIDTH+CW-1 -: 2]),
    .out_top_valid(out_ch.data[KEY_WIDTH+TAG_WIDTH+CW]),
    .out_top_key(out_ch.data[KEY_WIDTH+TAG_WIDTH+CW-1 -: KEY_WIDTH]),
    .out_top_tag(out_ch.data[TAG_WIDTH+CW-1 -: TAG_WIDTH]),
    .out_count(out_ch.data[CW-1:0]),
    .we, .waddr, .wdata, .raddr, .rdata
  );
endmodule

// File: rtl/bhpq_checker.sv
`timescale 1ns / 1ps
module bhpq_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [6:0] count,
  input logic top_valid
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("accepted twice");
  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result held");
  a_topv: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (top_valid == (count != 7'd0))) else $error("top_valid mismatch");
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count <= 7'd64) else $error("count over capacity");
endmodule

bind binary_heap_priority_queue_top bhpq_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .count(out_ch.data[6:0]), .top_valid(out_ch.data[55])
);

// File: dv/bhpq_tb_top.sv
`timescale 1ns / 1ps
module tb;
  import bhpq_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int IN_W = 2 + KEY_WIDTH_DEF + TAG_WIDTH_DEF;
  localparam int OUT_W = 2 + 1 + KEY_WIDTH_DEF + TAG_WIDTH_DEF + 7;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0] status;
    logic top_valid;
    logic [31:0] top_key;
    logic [15:0] top_tag;
    logic [6:0] count;
  } heap_result_t;

  class heap_scoreboard;
    logic [31:0] keys[CAP];
    logic [15:0] tags[CAP];
    int n;
    bit max_first;
    heap_result_t pending[$];
    int mismatches;

    function bit above(int a, int b);
      if (max_first) return keys[a] > keys[b];
      return keys[a] < keys[b];
    endfunction

    function void swap_at(int a, int b);
      logic [31:0] k;
      logic [15:0] t;
      k = keys[a]; t = tags[a];
      keys[a] = keys[b]; tags[a] = tags[b];
      keys[b] = k; tags[b] = t;
    endfunction

    function void rise(int p);
      while (p > 0 && above(p, (p - 1) / 2)) begin
        swap_at(p, (p - 1) / 2);
        p = (p - 1) / 2;
      end
    endfunction

    function void sink_down(int p);
      int l, pick;
      forever begin
        l = 2 * p + 1;
        if (l >= n) return;
        pick = l;
        if (l + 1 < n && above(l + 1, l)) pick = l + 1;
        if (!above(pick, p)) return;
        swap_at(p, pick);
        p = pick;
      end
    endfunction

    function void note_op(logic [1:0] op, logic [31:0] key, logic [15:0] tag);
      heap_result_t r;
      int hit;
      r = '0;
      r.status = ST_OK;
      if (op == OP_PUSH) begin
        if (n >= CAP) r.status = ST_FULL;
        else begin
          keys[n] = key; tags[n] = tag; n++;
          rise(n - 1);
        end
      end else if (op == OP_POP) begin
        if (n == 0) r.status = ST_EMPTY;
        else begin
          n--;
          keys[0] = keys[n]; tags[0] = tags[n];
          sink_down(0);
        end
      end else if (op == OP_REMOVE) begin
        hit = -1;
        for (int i = 0; i < n; i++)
          if (hit < 0 && tags[i] == tag) hit = i;
        if (hit < 0) r.status = ST_NOT_FOUND;
        else begin
          n--;
          if (hit < n) begin
            keys[hit] = keys[n]; tags[hit] = tags[n];
            if (hit > 0 && above(hit, (hit - 1) / 2)) rise(hit);
            else sink_down(hit);
          end
        end
      end
      if (n > 0) begin
        r.top_valid = 1'b1; r.top_key = keys[0]; r.top_tag = tags[0];
      end
      r.count = n[6:0];
      pending.push_back(r);
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  always #4 clk = ~clk;

  bhpq_if #(.W(1)) cfg ();
  bhpq_if #(.W(IN_W)) in_ch ();
  bhpq_if #(.W(OUT_W)) out_ch ();

  binary_heap_priority_queue_top dut (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  heap_scoreboard sb = new();
  int hold_off = 0;
  bit hold_go = 0;
  bit hold_armed = 0;
  bit in_flight_stress = 0;
  int cycles = 0;
  logic [15:0] recent_tags[$];

  function automatic int short_or_long_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(heap_result_t'(out_ch.data));

  always @(negedge clk) begin
    if (rst) out_ch.ready <= 0;
    else if (hold_go && !hold_armed) begin
      hold_armed <= 1;
      hold_off <= HOLD_CYCLES - 1;
      out_ch.ready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 0;
    end else if (!in_flight_stress && $urandom_range(0, 3) == 0)
      out_ch.ready <= 0;
    else out_ch.ready <= 1;
  end

  task automatic send_op(logic [1:0] op, logic [31:0] key, logic [15:0] tag, bit gaps);
    int g;
    g = gaps ? short_or_long_gap() : 0;
    @(negedge clk);
    repeat (g) @(negedge clk);
    in_ch.valid <= 1;
    in_ch.data <= {op, key, tag};
    do @(posedge clk); while (!in_ch.ready);
    sb.note_op(op, key, tag);
    if (op == OP_PUSH) recent_tags.push_back(tag);
    if (recent_tags.size() > 64) void'(recent_tags.pop_front());
    @(negedge clk);
    in_ch.valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_order(bit v);
    drain();
    cfg.valid <= 1;
    cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
    sb.max_first = v;
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_tag(bit for_remove);
    if (for_remove && recent_tags.size() > 0 && $urandom_range(0, 3) != 0)
      return recent_tags[$urandom_range(0, recent_tags.size() - 1)];
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
    return 16'($urandom);
  endfunction

  task automatic random_phase(int items, int push_weight);
    int r;
    logic [1:0] op;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if (r < push_weight) op = OP_PUSH;
      else if (r < push_weight + (100 - push_weight) / 2) op = OP_POP;
      else if (r < 98) op = OP_REMOVE;
      else op = OP_UNUSED;
      send_op(op, pick_key(), pick_tag(op == OP_REMOVE), $urandom_range(0, 4) != 0);
    end
  endtask

  initial begin
    cfg.valid = 0; cfg.data = 0;
    in_ch.valid = 0; in_ch.data = 0;
    sb.max_first = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    send_op(OP_POP, 32'h1, 16'h1, 0);
    send_op(OP_REMOVE, 32'h0, 16'h5, 0);
    send_op(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 0);
    send_op(OP_PUSH, 32'h0, 16'h0, 0);
    send_op(OP_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 0);
    send_op(OP_PUSH, 32'h8000_0000, 16'h1234, 0);
    send_op(OP_PUSH, 32'h8000_0000, 16'h4321, 0);
    send_op(OP_PUSH, 32'h5555_5555, 16'hAAAA, 0);
    send_op(OP_REMOVE, 32'h0, 16'hFFFF, 0);
    send_op(OP_REMOVE, 32'h0, 16'h9999, 0);
    send_op(OP_REMOVE, 32'h0, 16'h0, 0);
    send_op(OP_POP, 32'h0, 16'h0, 0);
    send_op(OP_POP, 32'h0, 16'h0, 0);
    send_op(OP_POP, 32'h0, 16'h0, 0);
    send_op(OP_POP, 32'h0, 16'h0, 0);

    write_order(0);
    for (int i = 0; i < CAP + 2; i++)
      send_op(OP_PUSH, $urandom, 16'(i), 0);
    send_op(OP_REMOVE, 32'h0, 16'(CAP - 1), 0);
    send_op(OP_REMOVE, 32'h0, 16'd3, 0);
    random_phase(300, 45);

    write_order(1);
    drain();
    hold_go <= 1;
    in_flight_stress = 1;
    random_phase(30, 60);
    in_flight_stress = 0;
    random_phase(500, 55);
    drain();
    random_phase(400, 40);

    write_order(0);
    random_phase(400, 50);
    write_order(1);
    random_phase(150, 30);

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
